@@ design/vt52_pkg.sv @@
package vt52_pkg;

	// configuration register indexes
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] REG_ROW_OFFSET    = 1'b0;
	localparam logic [CFG_IW-1:0] REG_COLUMN_OFFSET = 1'b1;
	localparam logic [7:0] OFFSET_RESET = 8'h20;

	// character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_B   = 8'h42;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_D   = 8'h44;
	localparam logic [7:0] CH_E   = 8'h45;
	localparam logic [7:0] CH_H   = 8'h48;
	localparam logic [7:0] CH_J   = 8'h4A;
	localparam logic [7:0] CH_K   = 8'h4B;
	localparam logic [7:0] CH_Y   = 8'h59;

	typedef enum logic [1:0] {
		ER_NONE   = 2'd0,
		ER_ALL    = 2'd1,
		ER_SCREEN = 2'd2,
		ER_LINE   = 2'd3
	} erase_t;

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_ROW  = 2'd2,
		PH_COL  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAIN,
		ST_FLUSH
	} seq_state_t;

	typedef enum logic [1:0] {
		SC_INIT,
		SC_IDLE,
		SC_COPY,
		SC_FILL
	} scr_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [5:0] cursor_col;
		logic [4:0] cursor_row;
		logic       cell_written;
		logic [5:0] cell_col;
		logic [4:0] cell_row;
		logic [7:0] cell_char;
		logic       scrolled;
		erase_t     erase_kind;
		logic       last_result;
	} res_item_t;

	// request to the screen memory; wr and scroll may come together
	typedef struct packed {
		logic       wr;
		logic       scroll;
		erase_t     erase;
		logic [4:0] row;
		logic [5:0] col;
		logic [7:0] data;
	} scr_cmd_t;

	typedef struct packed {
		logic busy;
		logic init;
	} scr_stat_t;

endpackage

@@ design/vt52_screen.sv @@
module vt52_screen #(
	parameter int COLUMNS = 40,
	parameter int ROWS    = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vt52_pkg::scr_cmd_t  cmd,
	output vt52_pkg::scr_stat_t stat
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_A    = AW'(DEPTH - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0] TAIL_A    = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS);

	vt52_pkg::scr_state_t state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] end_q, end_d;
	logic          cp_vld_s1;
	logic [AW-1:0] cp_addr_s1;
	logic [7:0]    rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [AW-1:0] raddr;
	logic [AW-1:0] cell_a;
	logic [AW-1:0] row_a;
	logic [7:0]    mem_q [DEPTH];

	assign cell_a = AW'(cmd.row * COLUMNS + cmd.col);
	assign row_a  = AW'(cmd.row * COLUMNS);
	assign raddr  = ptr_q + ROW_SPAN;

	assign stat.busy = (state_q != vt52_pkg::SC_IDLE);
	assign stat.init = (state_q == vt52_pkg::SC_INIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vt52_pkg::SC_INIT;
			ptr_q     <= '0;
			end_q     <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			ptr_q     <= ptr_d;
			end_q     <= end_d;
			cp_vld_s1 <= (state_q == vt52_pkg::SC_COPY);
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q;
		if (we)
			mem_q[waddr] <= wdata;
		if (state_q == vt52_pkg::SC_COPY)
			rd_q <= mem_q[raddr];
	end

	// copy runs as read at ptr+COLUMNS, write at ptr in the next cycle
	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		end_d   = end_q;
		we      = 1'b0;
		waddr   = ptr_q;
		wdata   = '0;
		case (state_q)
			vt52_pkg::SC_INIT: begin
				we    = 1'b1;
				ptr_d = ptr_q + AW'(1);
				if (ptr_q == LAST_A) begin
					ptr_d   = '0;
					state_d = vt52_pkg::SC_IDLE;
				end
			end
			vt52_pkg::SC_IDLE: begin
				if (cmd.wr) begin
					we    = 1'b1;
					waddr = cell_a;
					wdata = cmd.data;
				end
				if (cmd.scroll) begin
					ptr_d   = '0;
					state_d = vt52_pkg::SC_COPY;
				end else begin
					case (cmd.erase)
						vt52_pkg::ER_ALL: begin
							ptr_d   = '0;
							end_d   = LAST_A;
							state_d = vt52_pkg::SC_FILL;
						end
						vt52_pkg::ER_SCREEN: begin
							ptr_d   = cell_a;
							end_d   = LAST_A;
							state_d = vt52_pkg::SC_FILL;
						end
						vt52_pkg::ER_LINE: begin
							ptr_d   = cell_a;
							end_d   = row_a + ROW_SPAN - AW'(1);
							state_d = vt52_pkg::SC_FILL;
						end
						default: ;
					endcase
				end
			end
			vt52_pkg::SC_COPY: begin
				we    = cp_vld_s1;
				waddr = cp_addr_s1;
				wdata = rd_q;
				ptr_d = ptr_q + AW'(1);
				if (ptr_q == COPY_LAST) begin
					ptr_d   = TAIL_A;
					end_d   = LAST_A;
					state_d = vt52_pkg::SC_FILL;
				end
			end
			vt52_pkg::SC_FILL: begin
				we = 1'b1;
				if (cp_vld_s1) begin
					// drain the last copy write before blanking the bottom row
					waddr = cp_addr_s1;
					wdata = rd_q;
				end else begin
					ptr_d = ptr_q + AW'(1);
					if (ptr_q == end_q)
						state_d = vt52_pkg::SC_IDLE;
				end
			end
			default: state_d = vt52_pkg::SC_IDLE;
		endcase
	end

endmodule

@@ design/vt52_text_terminal_engine.sv @@
// Channel   Direction  Handshake                  Payload
// char      in         char_valid / char_ready    vt52_pkg::in_item_t
// res       out        res_valid / res_ready      vt52_pkg::res_item_t
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// A byte is taken while the sequencer is idle and decoded once it may go; each result is
// registered in the output register, and an input gives up to 3 results.
// Scroll walks the screen memory (one read and one write per cycle), moving rows up, then
// blanks the bottom row; erases blank each cleared cell. The next cell write waits for either walk.
// After reset the memory is cleared, all ROWS*COLUMNS cells, before char_ready rises.
// A held result in the output register stalls the sequencer, and with it the next input transfer.
module vt52_text_terminal_engine #(
	parameter int COLUMNS = 40,
	parameter int ROWS    = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            char_valid,
	output logic                            char_ready,
	input  vt52_pkg::in_item_t              char_item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output vt52_pkg::res_item_t             res_item,
	input  logic                            cfg_we,
	input  logic [vt52_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [7:0]                      cfg_data
);

	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam logic [CW-1:0] COL_MAX = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);

	vt52_pkg::seq_state_t state_q, state_d;
	vt52_pkg::phase_t     phase_q, phase_d, phase_n;
	vt52_pkg::scr_cmd_t   cmd;
	vt52_pkg::scr_stat_t  stat;
	vt52_pkg::res_item_t  res_q, res_d;

	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [7:0]    pend_q, pend_d;
	logic [1:0]    flush_left_q, flush_left_d;
	logic [1:0]    flush_idx_q, flush_idx_d;
	logic [7:0]    row_off_q, col_off_q;
	logic [7:0]    ch_q;
	logic          eos_q;
	logic          res_valid_q;
	logic          emit;
	logic          go;
	logic          take;

	logic [7:0]    rnd_byte;
	logic [7:0]    flush_byte;
	logic          rnd_nl, rnd_glyph, rnd_wrap, rnd_scroll;
	logic [CW-1:0] rnd_col;
	logic [RW-1:0] rnd_row;

	logic [8:0]    dr, dc;
	logic          addr_ok;

	vt52_screen #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_screen (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat)
	);

	assign char_ready = (state_q == vt52_pkg::ST_IDLE) && !stat.init;
	assign take       = char_valid && char_ready;
	assign res_valid  = res_valid_q;
	assign res_item   = res_q;
	assign go         = (!res_valid_q || res_ready) && !stat.busy;

	always_comb begin
		case (flush_idx_q)
			2'd0:    flush_byte = vt52_pkg::CH_ESC;
			2'd1:    flush_byte = vt52_pkg::CH_Y;
			default: flush_byte = pend_q;
		endcase
	end

	assign rnd_byte = (state_q == vt52_pkg::ST_FLUSH) ? flush_byte : ch_q;

	// one glyph or new line at the cursor
	assign rnd_nl     = (rnd_byte == vt52_pkg::CH_LF) || (rnd_byte == vt52_pkg::CH_CR);
	assign rnd_glyph  = !rnd_nl && (rnd_byte != vt52_pkg::CH_NUL);
	assign rnd_wrap   = rnd_nl || (rnd_glyph && (col_q == COL_MAX));
	assign rnd_scroll = rnd_wrap && (row_q == ROW_MAX);
	assign rnd_col    = rnd_wrap ? '0 : (rnd_glyph ? col_q + CW'(1) : col_q);
	assign rnd_row    = (rnd_wrap && !rnd_scroll) ? row_q + RW'(1) : row_q;

	// direct cursor address, both bytes must land on screen
	assign dr      = {1'b0, pend_q} - {1'b0, row_off_q};
	assign dc      = {1'b0, ch_q} - {1'b0, col_off_q};
	assign addr_ok = !dr[8] && (dr[7:0] < 8'(ROWS)) && !dc[8] && (dc[7:0] < 8'(COLUMNS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= vt52_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		logic       act;
		logic       eos;
		logic [1:0] cnt;
		act          = 1'b0;
		eos          = 1'b0;
		cnt          = 2'd0;
		state_d      = state_q;
		col_d        = col_q;
		row_d        = row_q;
		phase_n      = phase_q;
		phase_d      = phase_q;
		pend_d       = pend_q;
		flush_left_d = flush_left_q;
		flush_idx_d  = flush_idx_q;
		emit         = 1'b0;
		cmd          = '0;
		cmd.row      = 5'(row_q);
		cmd.col      = 6'(col_q);
		cmd.data     = rnd_byte;
		res_d        = '0;
		case (state_q)
			vt52_pkg::ST_IDLE: begin
				if (take)
					state_d = vt52_pkg::ST_MAIN;
			end
			vt52_pkg::ST_MAIN: begin
				if (go) begin
					eos = eos_q || (ch_q == vt52_pkg::CH_NUL);
					if (ch_q != vt52_pkg::CH_NUL) begin
						case (phase_q)
							vt52_pkg::PH_TEXT: begin
								if (ch_q == vt52_pkg::CH_ESC) begin
									phase_n = vt52_pkg::PH_ESC;
								end else begin
									act                = 1'b1;
									col_d              = rnd_col;
									row_d              = rnd_row;
									cmd.wr             = rnd_glyph;
									cmd.scroll         = rnd_scroll;
									res_d.cell_written = rnd_glyph;
									res_d.scrolled     = rnd_scroll;
								end
							end
							vt52_pkg::PH_ESC: begin
								if (ch_q == vt52_pkg::CH_Y) begin
									phase_n = vt52_pkg::PH_ROW;
								end else begin
									phase_n = vt52_pkg::PH_TEXT;
									case (ch_q)
										vt52_pkg::CH_A: begin
											act = 1'b1;
											if (row_q != '0)
												row_d = row_q - RW'(1);
										end
										vt52_pkg::CH_B: begin
											act = 1'b1;
											if (row_q != ROW_MAX)
												row_d = row_q + RW'(1);
										end
										vt52_pkg::CH_C: begin
											act = 1'b1;
											if (col_q != COL_MAX)
												col_d = col_q + CW'(1);
										end
										vt52_pkg::CH_D: begin
											act = 1'b1;
											if (col_q != '0)
												col_d = col_q - CW'(1);
										end
										vt52_pkg::CH_H: begin
											act   = 1'b1;
											col_d = '0;
											row_d = '0;
										end
										vt52_pkg::CH_E: begin
											act              = 1'b1;
											col_d            = '0;
											row_d            = '0;
											cmd.erase        = vt52_pkg::ER_ALL;
											res_d.erase_kind = vt52_pkg::ER_ALL;
										end
										vt52_pkg::CH_J: begin
											act              = 1'b1;
											cmd.erase        = vt52_pkg::ER_SCREEN;
											res_d.erase_kind = vt52_pkg::ER_SCREEN;
										end
										vt52_pkg::CH_K: begin
											act              = 1'b1;
											cmd.erase        = vt52_pkg::ER_LINE;
											res_d.erase_kind = vt52_pkg::ER_LINE;
										end
										default: ;
									endcase
								end
							end
							vt52_pkg::PH_ROW: begin
								pend_d  = ch_q;
								phase_n = vt52_pkg::PH_COL;
							end
							vt52_pkg::PH_COL: begin
								phase_n = vt52_pkg::PH_TEXT;
								act     = 1'b1;
								if (addr_ok) begin
									row_d = dr[RW-1:0];
									col_d = dc[CW-1:0];
								end
							end
							default: ;
						endcase
					end
					// pending escape bytes come back out as text
					cnt               = eos ? phase_n : 2'd0;
					emit              = act || (cnt == 2'd0);
					res_d.last_result = (cnt == 2'd0);
					phase_d           = eos ? vt52_pkg::PH_TEXT : phase_n;
					flush_left_d      = cnt;
					flush_idx_d       = 2'd0;
					state_d           = (cnt == 2'd0) ? vt52_pkg::ST_IDLE : vt52_pkg::ST_FLUSH;
				end
			end
			vt52_pkg::ST_FLUSH: begin
				if (go) begin
					emit               = 1'b1;
					col_d              = rnd_col;
					row_d              = rnd_row;
					cmd.wr             = rnd_glyph;
					cmd.scroll         = rnd_scroll;
					res_d.cell_written = rnd_glyph;
					res_d.scrolled     = rnd_scroll;
					res_d.last_result  = (flush_idx_q == flush_left_q - 2'd1);
					flush_idx_d        = flush_idx_q + 2'd1;
					if (res_d.last_result)
						state_d = vt52_pkg::ST_IDLE;
				end
			end
			default: state_d = vt52_pkg::ST_IDLE;
		endcase
		res_d.cursor_col = 6'(col_d);
		res_d.cursor_row = 5'(row_d);
		if (res_d.cell_written) begin
			res_d.cell_col  = 6'(col_q);
			res_d.cell_row  = 5'(row_q);
			res_d.cell_char = rnd_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			phase_q      <= vt52_pkg::PH_TEXT;
			pend_q       <= '0;
			flush_left_q <= '0;
			flush_idx_q  <= '0;
			res_valid_q  <= 1'b0;
			row_off_q    <= vt52_pkg::OFFSET_RESET;
			col_off_q    <= vt52_pkg::OFFSET_RESET;
		end else begin
			col_q        <= col_d;
			row_q        <= row_d;
			phase_q      <= phase_d;
			pend_q       <= pend_d;
			flush_left_q <= flush_left_d;
			flush_idx_q  <= flush_idx_d;
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					vt52_pkg::REG_ROW_OFFSET:    row_off_q <= cfg_data;
					vt52_pkg::REG_COLUMN_OFFSET: col_off_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_q  <= char_item.char_code;
			eos_q <= char_item.end_of_string;
		end
		if (emit)
			res_q <= res_d;
	end

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vt52_pkg::*;

	localparam int N_COLS = 40;
	localparam int N_ROWS = 24;
	localparam int MAX_REPORTS = 4;
	localparam int SETTLE_CYCLES = N_ROWS * N_COLS + 40;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 20000;
	localparam int ITEMS_PER_PHASE = 76;

	// Tracks cursor and escape state; the screen contents never reach the outputs.
	class cursor_tracker;
		logic [5:0] cur_col;
		logic [4:0] cur_row;
		phase_t     phase;
		logic [7:0] row_byte;
		logic [7:0] row_off;
		logic [7:0] col_off;
		res_item_t  reports[$];
		res_item_t  batch[$];
		int         n_bad;

		function new();
			cur_col = '0;
			cur_row = '0;
			phase = PH_TEXT;
			row_byte = '0;
			row_off = OFFSET_RESET;
			col_off = OFFSET_RESET;
			n_bad = 0;
		endfunction

		function void set_offset(logic [CFG_IW-1:0] idx, logic [7:0] v);
			if (idx == REG_ROW_OFFSET) begin
				row_off = v;
			end else begin
				col_off = v;
			end
		endfunction

		function void add_report(bit wr, logic [5:0] c, logic [4:0] r, logic [7:0] ch, bit scr,
				erase_t er);
			res_item_t it;
			if (batch.size() >= MAX_REPORTS) return;
			it = '0;
			it.cursor_col = cur_col;
			it.cursor_row = cur_row;
			if (wr) begin
				it.cell_written = 1'b1;
				it.cell_col = c;
				it.cell_row = r;
				it.cell_char = ch;
			end
			it.scrolled = scr;
			it.erase_kind = er;
			it.last_result = 1'b0;
			batch.push_back(it);
		endfunction

		function void add_quiet();
			add_report(1'b0, '0, '0, '0, 1'b0, ER_NONE);
		endfunction

		function bit line_feed();
			cur_col = '0;
			if (cur_row + 1 >= N_ROWS) begin
				cur_row = 5'(N_ROWS - 1);
				return 1'b1;
			end
			cur_row++;
			return 1'b0;
		endfunction

		function void put_glyph(logic [7:0] ch);
			logic [5:0] c;
			logic [4:0] r;
			bit scr;
			if (ch == CH_LF || ch == CH_CR) begin
				scr = line_feed();
				add_report(1'b0, '0, '0, '0, scr, ER_NONE);
			end else if (ch != CH_NUL) begin
				c = cur_col;
				r = cur_row;
				scr = 1'b0;
				cur_col++;
				if (cur_col >= N_COLS) scr = line_feed();
				add_report(1'b1, c, r, ch, scr, ER_NONE);
			end else begin
				add_quiet();
			end
		endfunction

		function void run_command(logic [7:0] ch);
			case (ch)
				CH_A: begin
					if (cur_row > 0) cur_row--;
					add_quiet();
				end
				CH_B: begin
					if (cur_row < N_ROWS - 1) cur_row++;
					add_quiet();
				end
				CH_C: begin
					if (cur_col < N_COLS - 1) cur_col++;
					add_quiet();
				end
				CH_D: begin
					if (cur_col > 0) cur_col--;
					add_quiet();
				end
				CH_H: begin
					cur_col = '0;
					cur_row = '0;
					add_quiet();
				end
				CH_E: begin
					cur_col = '0;
					cur_row = '0;
					add_report(1'b0, '0, '0, '0, 1'b0, ER_ALL);
				end
				CH_J: add_report(1'b0, '0, '0, '0, 1'b0, ER_SCREEN);
				CH_K: add_report(1'b0, '0, '0, '0, 1'b0, ER_LINE);
				default: ;  // unknown command: dropped
			endcase
		endfunction

		// pending escape bytes come out as text
		function void flush_escape();
			if (phase != PH_TEXT) put_glyph(CH_ESC);
			if (phase == PH_ROW || phase == PH_COL) put_glyph(CH_Y);
			if (phase == PH_COL) put_glyph(row_byte);
			phase = PH_TEXT;
		endfunction

		function void take_byte(in_item_t item);
			logic [7:0] ch;
			bit eos;
			int r;
			int c;
			res_item_t tail;
			ch = item.char_code;
			eos = item.end_of_string;
			batch.delete();
			if (ch == CH_NUL) begin
				eos = 1'b1;
			end else begin
				case (phase)
					PH_TEXT: begin
						if (ch == CH_ESC) phase = PH_ESC;
						else put_glyph(ch);
					end
					PH_ESC: begin
						if (ch == CH_Y) begin
							phase = PH_ROW;
						end else begin
							phase = PH_TEXT;
							run_command(ch);
						end
					end
					PH_ROW: begin
						row_byte = ch;
						phase = PH_COL;
					end
					default: begin
						phase = PH_TEXT;
						if (row_byte >= row_off && ch >= col_off) begin
							r = row_byte - row_off;
							c = ch - col_off;
							if (r < N_ROWS && c < N_COLS) begin
								cur_row = 5'(r);
								cur_col = 6'(c);
							end
						end
						add_quiet();
					end
				endcase
			end
			if (eos) flush_escape();
			if (batch.size() == 0) add_quiet();
			tail = batch.pop_back();
			tail.last_result = 1'b1;
			batch.push_back(tail);
			foreach (batch[i]) reports.push_back(batch[i]);
		endfunction

		function string show(res_item_t r);
			return $sformatf("cur=%0d,%0d wr=%0b cell=%0d,%0d ch=%02h scr=%0b er=%0d last=%0b",
				r.cursor_row, r.cursor_col, r.cell_written, r.cell_row, r.cell_col, r.cell_char,
				r.scrolled, r.erase_kind, r.last_result);
		endfunction

		function void match_report(res_item_t got);
			res_item_t want;
			if (reports.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result: %s", show(got));
				return;
			end
			want = reports.pop_front();
			if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
					got.cell_written !== want.cell_written || got.cell_col !== want.cell_col ||
					got.cell_row !== want.cell_row || got.cell_char !== want.cell_char ||
					got.scrolled !== want.scrolled || got.erase_kind !== want.erase_kind ||
					got.last_result !== want.last_result) begin
				n_bad++;
				if (n_bad <= 10) $display("mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_ready;
	in_item_t            char_item = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	res_item_t           res_item;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [7:0]          cfg_data = '0;

	cursor_tracker sb = new();
	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	bit  rx_hold = 1'b0;
	int  n_sent = 0;
	int  quiet = 0;

	vt52_text_terminal_engine #(
		.COLUMNS(N_COLS),
		.ROWS(N_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results first, so a result never matches a byte taken at the same edge
	always @(posedge clk) begin
		if (res_valid && res_ready) sb.match_report(res_item);
		if (char_valid && char_ready) sb.take_byte(char_item);
		if ((res_valid && res_ready) || (char_valid && char_ready)) quiet = 0;
		else quiet++;
	end

	initial begin
		while (quiet < QUIET_LIMIT) @(posedge clk);
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				res_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			res_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_byte(logic [7:0] c, logic e);
		while ($urandom_range(99) < tx_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= {c, e};
		do @(posedge clk); while (!char_ready);
		n_sent++;
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_offset(idx, v);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait out every result, then any memory walk still running
	task automatic settle();
		char_valid <= 1'b0;
		while (sb.reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic rnd_eos();
		return ($urandom_range(15) == 0);
	endfunction

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(19))
			0:       return CH_E;
			1:       return CH_J;
			2, 3:    return CH_A;
			4, 5:    return CH_B;
			6, 7:    return CH_C;
			8, 9:    return CH_D;
			10, 11:  return CH_H;
			12, 13:  return CH_K;
			14:      return CH_ESC;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_burst();
		int k;
		k = $urandom_range(99);
		if (k < 35) begin
			repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(8'h20, 8'h7E)), rnd_eos());
		end else if (k < 55) begin
			send_byte(CH_ESC, rnd_eos());
			send_byte(pick_cmd(), rnd_eos());
		end else if (k < 72) begin
			send_byte(CH_ESC, rnd_eos());
			send_byte(CH_Y, rnd_eos());
			send_byte(sb.row_off + 8'($urandom_range(N_ROWS - 1)), rnd_eos());
			send_byte(sb.col_off + 8'($urandom_range(N_COLS - 1)), rnd_eos());
		end else if (k < 78) begin
			send_byte(CH_ESC, rnd_eos());
			send_byte(CH_Y, rnd_eos());
			send_byte(8'($urandom_range(255)), rnd_eos());
			send_byte(8'($urandom_range(255)), rnd_eos());
		end else if (k < 86) begin
			send_byte($urandom_range(1) ? CH_CR : CH_LF, rnd_eos());
		end else begin
			send_byte(($urandom_range(9) == 0) ? CH_NUL : 8'($urandom_range(255)),
				1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, default offsets
		send_byte(8'hFF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_ESC, 1'b0); send_byte(CH_A, 1'b0);
		send_byte(CH_ESC, 1'b0); send_byte(CH_D, 1'b0);   // clamp at column 0
		send_byte(CH_ESC, 1'b0); send_byte(CH_Y, 1'b0);
		send_byte(OFFSET_RESET + 8'd23, 1'b0); send_byte(OFFSET_RESET + 8'd39, 1'b0);
		send_byte(CH_ESC, 1'b0); send_byte(CH_C, 1'b0);   // clamp at last column
		send_byte(8'h78, 1'b0);                           // wrap with scroll
		send_byte(CH_ESC, 1'b0); send_byte(CH_B, 1'b0);   // clamp at last row
		send_byte(CH_ESC, 1'b0); send_byte(CH_K, 1'b0);
		send_byte(CH_ESC, 1'b0); send_byte(CH_J, 1'b0);
		send_byte(CH_ESC, 1'b0); send_byte(CH_E, 1'b0);
		send_byte(CH_ESC, 1'b0); send_byte(CH_Y, 1'b0);
		send_byte(CH_LF, 1'b1);                           // flushed LF acts as new line
		send_byte(CH_ESC, 1'b0); send_byte(CH_NUL, 1'b0);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 57; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 57; end
				default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
			endcase
			if (p > 0) begin
				settle();
				case (p)
					1: begin
						write_reg(REG_ROW_OFFSET, 8'h00);
						write_reg(REG_COLUMN_OFFSET, 8'h00);
					end
					2: begin
						write_reg(REG_ROW_OFFSET, 8'hFF);
						write_reg(REG_COLUMN_OFFSET, 8'hFF);
					end
					default: begin
						write_reg(REG_ROW_OFFSET, 8'($urandom_range(255)));
						write_reg(REG_COLUMN_OFFSET, 8'($urandom_range(255)));
					end
				endcase
			end
			// long output hold while bytes keep coming, so the input side backs up
			if (p == 0) rx_hold = 1'b1;
			n_sent = 0;
			while (n_sent < ITEMS_PER_PHASE) begin
				random_burst();
				if (p == 2 && n_sent >= ITEMS_PER_PHASE / 2 && n_sent < ITEMS_PER_PHASE / 2 + 4)
					settle();
			end
		end

		settle();
		if (sb.n_bad == 0 && sb.reports.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
